>>> rtl/vt52_text_terminal_engine_macros.svh
// assertion helpers for the terminal engine
`ifndef VT52_TEXT_TERMINAL_ENGINE_MACROS_SVH
`define VT52_TEXT_TERMINAL_ENGINE_MACROS_SVH
// implication checked every clock outside reset
`define VT_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication outside reset
`define VT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`endif

>>> rtl/vt52_pkg.sv
package vt52_pkg;
  localparam int Rows = 24;
  localparam int Columns = 80;
  localparam int Cells = Rows * Columns;
  localparam int AddrW = $clog2(Cells);
  localparam int RowW = 5;
  localparam int ColW = 7;

  localparam logic [1:0] ModeByte = 2'd0;
  localparam logic [1:0] ModeRead = 2'd1;
  localparam logic [1:0] ModeReset = 2'd2;

  localparam logic [7:0] ChBel = 8'h07;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChFf = 8'h0c;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChEsc = 8'h1b;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [0:0] CfgText = 1'b0;
  localparam logic [0:0] CfgBack = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] fg;
    logic [2:0] bg;
  } cell_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [2:0] cell_fg;
    logic [2:0] cell_bg;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic cursor_shown;
    logic wrap_enabled;
    logic bell;
  } out_word_t;

  // memory access commands from controller to datapath
  typedef struct packed {
    logic wr;
    logic rd;
    logic [AddrW-1:0] addr;
    cell_t wdata;
  } mem_cmd_t;

  typedef struct packed {
    cell_t rdata;
  } mem_sts_t;
endpackage

>>> rtl/vt52_if.sv
interface vt52_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/vt52_cfg_if.sv
interface vt52_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [2:0] wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

>>> rtl/vt52_text_terminal_engine.sv
// a plain byte or move passes the decode and output states; a cell read adds a read-wait and a read-data state
// row erase and screen clear write blank cells through the fill state, a screen clear all 1920 cells
// scroll moves each cell with a read state and a write state, then fills the bottom row
// one word in flight at a time: a word is taken only in the idle state with no result pending
// after reset a clearing pass writes all 1920 cells before the first word is taken
module vt52_text_terminal_engine (
  input logic clk_i,
  input logic rst_ni,
  vt52_if.sink in_ch,
  vt52_if.source out_ch,
  vt52_cfg_if.sink cfg_ch
);
  import vt52_pkg::*;
  mem_cmd_t cmd;
  mem_sts_t sts;
  in_word_t in_word;
  out_word_t out_word;

  assign in_word = in_ch.data;
  assign out_ch.data = out_word;

  vt52_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_word_i(in_word),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_word_o(out_word),
    .cfg_valid_i(cfg_ch.valid), .cfg_ready_o(cfg_ch.ready),
    .cfg_index_i(cfg_ch.index), .cfg_wdata_i(cfg_ch.wdata),
    .cmd_o(cmd), .sts_i(sts)
  );

  vt52_mem u_mem (.clk_i, .cmd_i(cmd), .sts_o(sts));
endmodule

>>> rtl/vt52_mem.sv
module vt52_mem (
  input logic clk_i,
  input vt52_pkg::mem_cmd_t cmd_i,
  output vt52_pkg::mem_sts_t sts_o
);
  import vt52_pkg::*;
  cell_t mem_q [Cells];
  cell_t rd_q;

  // single port screen store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[cmd_i.addr] <= cmd_i.wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[cmd_i.addr];
    end
  end
  assign sts_o.rdata = rd_q;
endmodule

>>> rtl/vt52_ctrl.sv
module vt52_ctrl (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  output logic in_ready_o,
  input vt52_pkg::in_word_t in_word_i,
  output logic out_valid_o,
  input logic out_ready_i,
  output vt52_pkg::out_word_t out_word_o,
  input logic cfg_valid_i,
  output logic cfg_ready_o,
  input logic [0:0] cfg_index_i,
  input logic [2:0] cfg_wdata_i,
  output vt52_pkg::mem_cmd_t cmd_o,
  input vt52_pkg::mem_sts_t sts_i
);
  import vt52_pkg::*;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StDecode = 4'd2;
  localparam logic [3:0] StFill = 4'd3;
  localparam logic [3:0] StScrRd = 4'd4;
  localparam logic [3:0] StScrWr = 4'd5;
  localparam logic [3:0] StReadWait = 4'd6;
  localparam logic [3:0] StReadData = 4'd7;
  localparam logic [3:0] StOut = 4'd8;

  logic [3:0] state_q, state_d;
  in_word_t item_q, item_d;
  logic [RowW-1:0] row_q, row_d, srow_q, srow_d;
  logic [ColW-1:0] col_q, col_d, scol_q, scol_d;
  logic esc_q, esc_d, con_q, con_d, wrap_q, wrap_d, bell_q, bell_d;
  logic [2:0] fgc_q, fgc_d, bgc_q, bgc_d;
  logic [AddrW-1:0] ptr_q, ptr_d, end_q, end_d;
  logic [AddrW-1:0] cur_addr, row_base;
  cell_t rcell_q, rcell_d;
  logic outv_q, outv_d;
  logic inrange;
  cell_t blank;

  assign row_base = AddrW'(row_q) * AddrW'(Columns);
  assign cur_addr = row_base + AddrW'(col_q);
  assign blank = '{ch: ChSpace, fg: fgc_q, bg: bgc_q};
  assign inrange = (item_q.read_row < RowW'(Rows)) && (item_q.read_col < ColW'(Columns));
  assign in_ready_o = (state_q == StIdle) && !outv_q;
  // register writes only while nothing is in flight
  assign cfg_ready_o = (state_q == StIdle) && !outv_q;

  // next-state and datapath control
  always_comb begin
    logic [ColW:0] tcol;
    logic escdone;
    state_d = state_q; item_d = item_q; row_d = row_q; col_d = col_q;
    srow_d = srow_q; scol_d = scol_q; esc_d = esc_q; con_d = con_q;
    wrap_d = wrap_q; bell_d = bell_q; fgc_d = fgc_q; bgc_d = bgc_q;
    ptr_d = ptr_q; end_d = end_q; rcell_d = rcell_q; outv_d = outv_q;
    cmd_o = '{wr: 1'b0, rd: 1'b0, addr: cur_addr, wdata: blank};
    tcol = '0;
    escdone = 1'b0;
    if (outv_q && out_ready_i) outv_d = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgText) fgc_d = cfg_wdata_i;
      else bgc_d = cfg_wdata_i;
    end
    case (state_q)
      StClear: begin
        cmd_o.wr = 1'b1; cmd_o.addr = ptr_q;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == end_q) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          item_d = in_word_i; bell_d = 1'b0; rcell_d = '0;
          state_d = StDecode;
        end
      end
      StDecode: begin
        state_d = StOut;
        if (item_q.mode == ModeRead) begin
          if (inrange) begin
            cmd_o.rd = 1'b1;
            cmd_o.addr = AddrW'(item_q.read_row) * AddrW'(Columns) + AddrW'(item_q.read_col);
            state_d = StReadWait;
          end
        end else if (item_q.mode == ModeReset) begin
          fgc_d = 3'd7; bgc_d = 3'd0; con_d = 1'b1; wrap_d = 1'b1;
          srow_d = '0; scol_d = '0; esc_d = 1'b0; row_d = '0; col_d = '0;
          ptr_d = '0; end_d = AddrW'(Cells - 1); state_d = StFill;
        end else if (item_q.mode == ModeByte) begin
          if (esc_q) begin
            esc_d = 1'b0; escdone = 1'b1;
            case (item_q.data_byte)
              "A": if (row_q != 0) row_d = row_q - 1'b1;
              "B": if (row_q != RowW'(Rows - 1)) row_d = row_q + 1'b1;
              "C": if (col_q != ColW'(Columns - 1)) col_d = col_q + 1'b1;
              "D": if (col_q != 0) col_d = col_q - 1'b1;
              "H": begin row_d = '0; col_d = '0; end
              "K": begin
                ptr_d = cur_addr; end_d = row_base + AddrW'(Columns - 1);
                state_d = StFill;
              end
              "E": begin
                row_d = '0; col_d = '0; ptr_d = '0; end_d = AddrW'(Cells - 1);
                state_d = StFill;
              end
              "e": con_d = 1'b1;
              "f": con_d = 1'b0;
              "j": begin srow_d = row_q; scol_d = col_q; end
              "k": begin row_d = srow_q; col_d = scol_q; end
              "l": begin
                col_d = '0; ptr_d = row_base; end_d = row_base + AddrW'(Columns - 1);
                state_d = StFill;
              end
              "o": begin
                if (col_q != 0) begin
                  ptr_d = row_base; end_d = cur_addr - 1'b1; state_d = StFill;
                end
              end
              "v": wrap_d = 1'b1;
              "w": wrap_d = 1'b0;
              default: escdone = 1'b0;
            endcase
          end
          if (!escdone) begin
            case (item_q.data_byte)
              ChBel: bell_d = 1'b1;
              ChBs: begin
                if (col_q != 0) begin
                  col_d = col_q - 1'b1;
                  cmd_o.wr = 1'b1; cmd_o.addr = cur_addr - 1'b1;
                end else if (row_q != 0) begin
                  col_d = ColW'(Columns - 1); row_d = row_q - 1'b1;
                  cmd_o.wr = 1'b1; cmd_o.addr = cur_addr - 1'b1;
                end else bell_d = 1'b1;
              end
              ChLf: if (row_q != RowW'(Rows - 1)) row_d = row_q + 1'b1;
              ChFf: begin
                row_d = '0; col_d = '0; ptr_d = '0; end_d = AddrW'(Cells - 1);
                state_d = StFill;
              end
              // carriage return is handled below; it also advances the row or scrolls
              ChCr: col_d = '0;
              ChEsc: esc_d = 1'b1;
              default: begin
                if (item_q.data_byte == ChTab) begin
                  tcol = ({1'b0, col_q} + (ColW + 1)'(8)) & ~(ColW + 1)'(7);
                end else begin
                  cmd_o.wr = 1'b1;
                  cmd_o.wdata = '{ch: item_q.data_byte, fg: fgc_q, bg: bgc_q};
                  tcol = {1'b0, col_q} + 1'b1;
                end
                col_d = tcol[ColW-1:0];
                if (tcol >= (ColW + 1)'(Columns)) begin
                  if (wrap_q) begin
                    col_d = '0;
                  end else col_d = ColW'(Columns - 1);
                end
              end
            endcase
            // carriage return and row advance or scroll, also on wrap
            if (item_q.data_byte == ChCr ||
                (tcol >= (ColW + 1)'(Columns) && wrap_q &&
                 item_q.data_byte != ChBel && item_q.data_byte != ChBs &&
                 item_q.data_byte != ChLf && item_q.data_byte != ChFf &&
                 item_q.data_byte != ChEsc)) begin
              col_d = '0;
              if (row_q >= RowW'(Rows - 1)) begin
                ptr_d = '0; state_d = StScrRd;
              end else row_d = row_q + 1'b1;
            end
          end
        end
      end
      StFill: begin
        cmd_o.wr = 1'b1; cmd_o.addr = ptr_q;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == end_q) state_d = StOut;
      end
      StScrRd: begin
        if (ptr_q == AddrW'(Cells - Columns)) begin
          end_d = AddrW'(Cells - 1); state_d = StFill;
        end else begin
          cmd_o.rd = 1'b1; cmd_o.addr = ptr_q + AddrW'(Columns);
          state_d = StScrWr;
        end
      end
      StScrWr: begin
        cmd_o.wr = 1'b1; cmd_o.addr = ptr_q; cmd_o.wdata = sts_i.rdata;
        ptr_d = ptr_q + 1'b1; state_d = StScrRd;
      end
      StReadWait: state_d = StReadData;
      StReadData: begin
        rcell_d = sts_i.rdata; state_d = StOut;
      end
      StOut: begin
        outv_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control and cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; row_q <= '0; col_q <= '0; srow_q <= '0; scol_q <= '0;
      esc_q <= 1'b0; con_q <= 1'b1; wrap_q <= 1'b1; bell_q <= 1'b0;
      fgc_q <= 3'd7; bgc_q <= 3'd0; ptr_q <= '0; end_q <= AddrW'(Cells - 1);
      outv_q <= 1'b0;
    end else begin
      state_q <= state_d; row_q <= row_d; col_q <= col_d; srow_q <= srow_d;
      scol_q <= scol_d; esc_q <= esc_d; con_q <= con_d; wrap_q <= wrap_d;
      bell_q <= bell_d; fgc_q <= fgc_d; bgc_q <= bgc_d; ptr_q <= ptr_d;
      end_q <= end_d; outv_q <= outv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rcell_q <= rcell_d;
  end

  assign out_valid_o = outv_q;
  assign out_word_o = '{cell_char: rcell_q.ch, cell_fg: rcell_q.fg, cell_bg: rcell_q.bg,
                        cursor_row: row_q, cursor_col: col_q, cursor_shown: con_q,
                        wrap_enabled: wrap_q, bell: bell_q};
endmodule

>>> rtl/vt52_checker.sv
`include "vt52_text_terminal_engine_macros.svh"
module vt52_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [28:0] out_data
);
  // no new word while a result is pending
  `VT_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready)
  // stalled result holds
  `VT_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
  // accepted word gives no result in the next cycle
  `VT_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_valid && in_ready, !out_valid && !in_ready)
endmodule

bind vt52_text_terminal_engine vt52_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
